@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL of the hash table.
// Needs a clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/oaht_pkg.sv @@
// Package for the open-addressed hash table: request/result types,
// mode and status codes, default sizes. No dependencies.
`default_nettype none

package oaht_pkg;

  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int CAP_W    = 11;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 3;
  localparam int MODE_W   = 2;

  localparam int SLOTS_DEFAULT      = 1024;
  localparam int MAX_PROBES_DEFAULT = 64;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1021;

  localparam logic [MODE_W-1:0] MODE_FIND    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UPSERT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_REPLACE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_KEPT     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd6;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] slot_index;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    value_out;
    logic [SLOT_W-1:0]   slot_out;
    logic [CAP_W-1:0]    entry_total;
  } result_t;

endpackage

`default_nettype wire

@@ design/open_address_hash_table.sv @@
// Open-addressed key/value table, top level.
// Depends on oaht_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

// Key/value table with quadratic probing over the active capacity. A
// request is taken when start is high and busy is low; its single result
// comes with a one-cycle done pulse and must be taken then: the receiver
// cannot stall the block. Keys and values live in two single-port style
// synchronous memories with a registered read. After reset the key memory
// is swept to zero, one slot per cycle, with busy high (capacity writes
// are still taken). A request with key zero or a replace with an
// out-of-range slot answers from idle; a replace-at-slot runs S_RD, S_CHK3.
// A probing request runs S_DIV, S_RD, S_CHK for the home slot and S_MUL,
// S_DIV, S_RD, S_CHK for each further probe: the remainder by the capacity
// is found by one shared restoring divider, one bit per cycle, and that
// divider sets the pace (DIV_W = 32 at default sizes). Requests are handled
// one at a time; done and a new start may share a cycle. The user must
// write the capacity register through cfg_valid/cfg_ready/cfg_data only
// while no request is in flight; the block does not enforce it.
module open_address_hash_table #(
  parameter int SLOTS      = oaht_pkg::SLOTS_DEFAULT,
  parameter int MAX_PROBES = oaht_pkg::MAX_PROBES_DEFAULT
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  oaht_pkg::request_t          request,
  output logic                        done,
  output oaht_pkg::result_t           result,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire [oaht_pkg::CAP_W-1:0]   cfg_data
);

  localparam int IW    = $clog2(SLOTS);
  localparam int AW    = $clog2(MAX_PROBES + 1);
  localparam int MW    = ((IW > AW) ? IW : AW) + 1;
  localparam int PW    = (((IW + MW) > (2 * AW)) ? (IW + MW) : (2 * AW)) + 1;
  localparam int DIV_W = (oaht_pkg::KEY_W > PW) ? oaht_pkg::KEY_W : PW;
  localparam int CW    = $clog2(DIV_W + 1);
  localparam int CAPW  = oaht_pkg::CAP_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_CHK3  = 3'd6;

  // storage
  logic [oaht_pkg::KEY_W-1:0] key_mem [SLOTS];
  logic [oaht_pkg::VAL_W-1:0] val_mem [SLOTS];
  logic [oaht_pkg::KEY_W-1:0] rd_key;
  logic [oaht_pkg::VAL_W-1:0] rd_val;

  // control
  logic [2:0]      state;
  logic [IW-1:0]   clr_idx;
  logic [CAPW-1:0] cap_reg;
  logic [CAPW-1:0] entry_count;

  // per-request payload
  logic [oaht_pkg::MODE_W-1:0] mode;
  logic [oaht_pkg::KEY_W-1:0]  key;
  logic [oaht_pkg::VAL_W-1:0]  value;
  logic [IW-1:0]               h;
  logic [AW-1:0]               a_cnt;
  logic [DIV_W-1:0]            div;
  logic [CAPW-1:0]             rem;
  logic [CW-1:0]               bit_cnt;

  logic [CAPW-1:0]  eff_cap;
  logic [CAPW:0]    div_t;
  logic [CAPW:0]    div_r;
  logic [CAPW-1:0]  rem_step;
  logic [MW-1:0]    sum_ha;
  logic [DIV_W-1:0] mul_sum;
  logic             hit;
  logic             empty;
  logic             room;
  logic             last_probe;
  logic             key_we;
  logic             val_we;
  logic [IW-1:0]    wr_addr;
  logic [oaht_pkg::KEY_W-1:0] wr_key;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // capacity 0 acts as 1, anything above the memory size as the size
  always_comb begin
    if (cap_reg == '0) begin
      eff_cap = CAPW'(1);
    end else if (int'(cap_reg) > SLOTS) begin
      eff_cap = CAPW'(SLOTS);
    end else begin
      eff_cap = cap_reg;
    end
  end

  // one restoring step of the remainder by eff_cap
  assign div_t    = {rem, div[DIV_W-1]};
  assign div_r    = (div_t >= {1'b0, eff_cap}) ? (div_t - {1'b0, eff_cap}) : div_t;
  assign rem_step = CAPW'(div_r);

  // next probe: h*h + a*h + a*a = h*(h+a) + a*a
  assign sum_ha  = MW'(h) + MW'(a_cnt);
  assign mul_sum = (DIV_W'(h) * DIV_W'(sum_ha)) + (DIV_W'(a_cnt) * DIV_W'(a_cnt));

  assign hit        = (rd_key == key);
  assign empty      = (rd_key == '0);
  assign room       = (entry_count < eff_cap);
  assign last_probe = ((int'(a_cnt) + 1) >= MAX_PROBES);

  always_comb begin
    key_we  = 1'b0;
    val_we  = 1'b0;
    wr_addr = h;
    wr_key  = key;
    case (state)
      S_CLEAR: begin
        key_we  = 1'b1;
        wr_addr = clr_idx;
        wr_key  = '0;
      end
      S_CHK: begin
        if (hit) begin
          val_we = (mode == oaht_pkg::MODE_UPSERT);
        end else if (empty && mode != oaht_pkg::MODE_FIND && room) begin
          key_we = 1'b1;
          val_we = 1'b1;
        end
      end
      S_CHK3: begin
        val_we = hit;
      end
      default: begin
        key_we = 1'b0;
      end
    endcase
  end

  // memories: one write port, registered read
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (val_we) begin
      val_mem[wr_addr] <= value;
    end
    if (state == S_RD) begin
      rd_key <= key_mem[h];
      rd_val <= val_mem[h];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      cap_reg     <= oaht_pkg::CAP_RESET;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        cap_reg <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            mode  <= request.mode;
            key   <= request.key;
            value <= request.value;
            a_cnt <= '0;
            result.entry_total <= entry_count;
            if (request.key == '0) begin
              result.status    <= oaht_pkg::ST_MISS;
              result.value_out <= '0;
              result.slot_out  <= '0;
              done             <= 1'b1;
            end else if (request.mode == oaht_pkg::MODE_REPLACE) begin
              result.slot_out <= request.slot_index;
              if (CAPW'(request.slot_index) >= eff_cap) begin
                result.status    <= oaht_pkg::ST_MISMATCH;
                result.value_out <= '0;
                done             <= 1'b1;
              end else begin
                h     <= IW'(request.slot_index);
                state <= S_RD;
              end
            end else begin
              div     <= DIV_W'(request.key);
              rem     <= '0;
              bit_cnt <= CW'(DIV_W);
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem     <= rem_step;
          div     <= div << 1;
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == CW'(1)) begin
            h     <= IW'(rem_step);
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= (mode == oaht_pkg::MODE_REPLACE) ? S_CHK3 : S_CHK;
        end
        S_CHK: begin
          result.slot_out <= oaht_pkg::SLOT_W'(h);
          if (hit || empty) begin
            state <= S_IDLE;
            done  <= 1'b1;
            if (hit) begin
              case (mode)
                oaht_pkg::MODE_FIND: begin
                  result.status    <= oaht_pkg::ST_HIT;
                  result.value_out <= rd_val;
                end
                oaht_pkg::MODE_INSERT: begin
                  result.status    <= oaht_pkg::ST_KEPT;
                  result.value_out <= rd_val;
                end
                default: begin
                  result.status    <= oaht_pkg::ST_REPLACED;
                  result.value_out <= value;
                end
              endcase
            end else if (mode == oaht_pkg::MODE_FIND) begin
              result.status    <= oaht_pkg::ST_MISS;
              result.value_out <= '0;
            end else if (!room) begin
              result.status    <= oaht_pkg::ST_FULL;
              result.value_out <= '0;
            end else begin
              result.status      <= oaht_pkg::ST_INSERTED;
              result.value_out   <= value;
              result.entry_total <= entry_count + 1'b1;
              entry_count        <= entry_count + 1'b1;
            end
          end else if (last_probe) begin
            state            <= S_IDLE;
            done             <= 1'b1;
            result.status    <= oaht_pkg::ST_FULL;
            result.value_out <= '0;
          end else begin
            a_cnt <= a_cnt + 1'b1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          div     <= mul_sum;
          rem     <= '0;
          bit_cnt <= CW'(DIV_W);
          state   <= S_DIV;
        end
        S_CHK3: begin
          state <= S_IDLE;
          done  <= 1'b1;
          if (hit) begin
            result.status    <= oaht_pkg::ST_REPLACED;
            result.value_out <= rd_val;
          end else begin
            result.status    <= oaht_pkg::ST_MISMATCH;
            result.value_out <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a result always lands as the request retires
  `ASSERT_SAME(a_done_idle, done, state == S_IDLE)
  // a probing request goes busy and never answers in the next cycle
  `ASSERT_NEXT(a_probe_busy, start && !busy && request.key != '0 && request.mode != oaht_pkg::MODE_REPLACE, busy && !done)
  // probe addresses stay inside the active capacity
  `ASSERT_SAME(a_probe_range, state == S_CHK, CAPW'(h) < eff_cap)
  // the entry count only ever steps up by one
  `ASSERT_NEXT(a_count_step, 1'b1,
               entry_count == $past(entry_count) ||
               entry_count == $past(entry_count) + CAPW'(1))

endmodule

`default_nettype wire
